FILE: sv/key_debounce_press_classifier_macros.svh
// assertion macros for the key debounce press classifier
`ifndef KEY_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH
`define KEY_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked outside reset
`define KDPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define KDPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/kdpc_pkg.sv
// shared types and constants for the key debounce press classifier
package kdpc_pkg;

    localparam int KEY_COUNT_DEF = 4;

    localparam int KEY_W    = 2;
    localparam int RUN_W    = 8;
    localparam int HELD_W   = 16;
    localparam int MASK_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [RUN_W-1:0]  RUN_MAX  = '1;
    localparam logic [HELD_W-1:0] HELD_MAX = '1;

    localparam logic [RUN_W-1:0]  DEBOUNCE_RST  = 8'd3;
    localparam logic [HELD_W-1:0] LONG_TICKS_RST = 16'd100;
    localparam logic [MASK_W-1:0] LONG_MASK_RST = 4'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MASK  = 2'd2;

    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_LONG  = 1'b1;

    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             kind;
    } event_t;

    typedef struct packed {
        logic   valid;
        event_t evt;
    } event_req_t;

    typedef struct packed {
        logic              last_level;
        logic [RUN_W-1:0]  run_count;
        logic              debounced_level;
        logic [HELD_W-1:0] held_count;
        logic              long_reported;
    } key_slot_t;

endpackage

FILE: sv/kdpc_front.sv
// front end: sample intake, per-key debounce state and press classification
module kdpc_front #(
    parameter int KEY_COUNT = kdpc_pkg::KEY_COUNT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [kdpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kdpc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             sample_take,
    input  logic [kdpc_pkg::KEY_W-1:0]       key_index,
    input  logic                             raw_level,
    input  logic                             read_ok,
    output kdpc_pkg::event_req_t             push
);
    import kdpc_pkg::*;

    logic [RUN_W-1:0]  debounce_reg;
    logic [HELD_W-1:0] long_ticks_reg;
    logic [MASK_W-1:0] long_mask_reg;

    key_slot_t key_reg [KEY_COUNT];
    key_slot_t key_cur;
    key_slot_t key_next;
    logic       key_hit;
    logic [RUN_W-1:0]  run_inc;
    logic [HELD_W-1:0] held_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RST;
            long_ticks_reg <= LONG_TICKS_RST;
            long_mask_reg  <= LONG_MASK_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DEBOUNCE_TICKS:   debounce_reg   <= cfg_wdata[RUN_W-1:0];
                CFG_LONG_PRESS_TICKS: long_ticks_reg <= cfg_wdata[HELD_W-1:0];
                CFG_LONG_PRESS_MASK:  long_mask_reg  <= cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // select the addressed key
    always_comb begin
        key_cur = key_reg[0];
        key_hit = 1'b0;
        for (int i = 0; i < KEY_COUNT; i++) begin
            if (32'(key_index) == i) begin
                key_cur = key_reg[i];
                key_hit = 1'b1;
            end
        end
    end

    assign run_inc  = (key_cur.run_count == RUN_MAX) ? RUN_MAX : key_cur.run_count + 1'b1;
    assign held_inc = (key_cur.held_count == HELD_MAX) ? HELD_MAX
                                                       : key_cur.held_count + 1'b1;

    always_comb begin
        key_next       = key_cur;
        push.valid     = 1'b0;
        push.evt.key   = key_index;
        push.evt.kind  = KIND_SHORT;
        if (raw_level != key_cur.last_level) begin
            key_next.last_level = raw_level;
            key_next.run_count  = '0;
        end else begin
            key_next.run_count = run_inc;
            if (run_inc >= debounce_reg) begin
                if (raw_level != key_cur.debounced_level) begin
                    key_next.debounced_level = raw_level;
                    key_next.held_count      = '0;
                    if (raw_level) begin
                        key_next.long_reported = 1'b0;
                    end else if (!key_cur.long_reported) begin
                        push.valid = sample_take && read_ok && key_hit;
                    end
                end else if (raw_level) begin
                    key_next.held_count = held_inc;
                    if (long_mask_reg[key_index] && !key_cur.long_reported
                        && held_inc >= long_ticks_reg) begin
                        key_next.long_reported = 1'b1;
                        push.valid    = sample_take && read_ok && key_hit;
                        push.evt.kind = KIND_LONG;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < KEY_COUNT; i++) begin
            if (!aresetn) begin
                key_reg[i].last_level      <= 1'b0;
                key_reg[i].run_count       <= DEBOUNCE_RST;
                key_reg[i].debounced_level <= 1'b0;
                key_reg[i].held_count      <= '0;
                key_reg[i].long_reported   <= 1'b0;
            end else if (sample_take && read_ok && 32'(key_index) == i) begin
                key_reg[i] <= key_next;
            end
        end
    end

endmodule

FILE: sv/kdpc_queue.sv
// short event queue between front end and output stage
module kdpc_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  kdpc_pkg::event_req_t push,
    input  logic                 pop,
    output kdpc_pkg::event_t     head,
    output logic                 empty,
    output logic                 full
);
    import kdpc_pkg::*;

    event_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.evt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/kdpc_back.sv
// output stage: holds one event request for the result channel
module kdpc_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  kdpc_pkg::event_t head,
    input  logic             empty,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output kdpc_pkg::event_t m_event
);
    import kdpc_pkg::*;

    logic   out_valid_reg, out_valid_next;
    event_t out_evt_reg;

    assign pop = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = !empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && !empty) begin
            out_evt_reg <= head;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_event = out_evt_reg;

endmodule

FILE: sv/key_debounce_press_classifier.sv
// top level: debounces scanned keys and reports short and long presses
// a sample is taken every cycle while the 4-entry event queue has room
// an event is registered first into the event queue, then into the output register
// (the output register holds its event while m_ready is low)
// the per-key read-modify-write takes one sample per cycle while the queue has room
// synchronous active-low reset: keys released and stable, registers at defaults, queue empty
`include "key_debounce_press_classifier_macros.svh"

module key_debounce_press_classifier #(
    parameter int KEY_COUNT = kdpc_pkg::KEY_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [kdpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kdpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [kdpc_pkg::KEY_W-1:0]      s_key_index,
    input  logic                            s_raw_level,
    input  logic                            s_read_ok,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [kdpc_pkg::KEY_W-1:0]      m_event_key,
    output logic                            m_event_kind
);
    import kdpc_pkg::*;

    event_req_t push;
    event_t     head;
    event_t     m_event;
    logic       q_empty, q_full, q_pop;
    logic       sample_take;

    assign s_ready     = !q_full;
    assign sample_take = s_valid && s_ready;

    kdpc_front #(
        .KEY_COUNT(KEY_COUNT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .sample_take (sample_take),
        .key_index   (s_key_index),
        .raw_level   (s_raw_level),
        .read_ok     (s_read_ok),
        .push        (push)
    );

    kdpc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (q_pop),
        .head    (head),
        .empty   (q_empty),
        .full    (q_full)
    );

    kdpc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .empty   (q_empty),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_event (m_event)
    );

    assign m_event_key  = m_event.key;
    assign m_event_kind = m_event.kind;

    `KDPC_ASSERT_NOW(a_no_event_on_bad_read, sample_take && !s_read_ok, !push.valid, "event from failed read")
    `KDPC_ASSERT_NOW(a_no_push_when_full, push.valid, !q_full, "event pushed into full queue")
    `KDPC_ASSERT_NOW(a_long_only_when_pressed, push.valid && push.evt.kind == KIND_LONG, s_raw_level, "long press on released sample")
    `KDPC_ASSERT_NEXT(a_event_reaches_output, !q_empty && !m_valid, m_valid, "queued event not moved out")

endmodule
